[rtl/tldt_pkg.sv]
// Package for the two-level directory table: sizes, codes and address helpers.
// No dependencies; used by two_level_directory_table_core.
`default_nettype none

package tldt_pkg;

    localparam int DIR_SLOTS  = 16;
    localparam int FILE_SLOTS = 16;

    localparam int NAME_W     = 64;
    localparam int SLOT_W     = 4;
    localparam int DIW        = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
    localparam int FIW        = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int DCW        = $clog2(DIR_SLOTS + 1);
    localparam int FCW        = $clog2(FILE_SLOTS + 1);
    localparam int FILE_DEPTH = DIR_SLOTS * FILE_SLOTS;
    localparam int FAW        = $clog2(FILE_DEPTH);

    localparam int IN_W       = 136;
    localparam int OUT_W      = 16;

    typedef enum logic [1:0] {
        FN_MKDIR  = 2'd0,
        FN_MKFILE = 2'd1,
        FN_DELETE = 2'd2,
        FN_SEARCH = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_DIR    = 3'd1,
        ST_NO_FILE   = 3'd2,
        ST_DIR_FULL  = 3'd3,
        ST_FILE_FULL = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSCAN,
        S_FSCAN,
        S_DEL,
        S_DONE
    } state_t;

    // Flat file-name address of slot k in directory d.
    function automatic logic [FAW-1:0] file_addr(input logic [DIW-1:0] d,
                                                 input logic [FIW-1:0] k);
        logic [FAW-1:0] base;
        base = FAW'(FAW'(d) * FAW'(FILE_SLOTS));
        return FAW'(base + FAW'(k));
    endfunction

endpackage

`default_nettype wire

[rtl/two_level_directory_table_core.sv]
// Top level of the two-level directory table: stream ports, sequencer, count state.
// Depends on tldt_pkg and tldt_ram.
`default_nettype none

// Two-level name table. Each input beat carries an operation and one or two
// 64-bit names; each request returns exactly one result beat with a status and
// the matched directory and file slots. Create directory appends (duplicates
// allowed); create file, delete and search act on the first directory whose
// name matches, and delete moves the last file into the freed slot. Requests
// are handled one at a time through a single 64-bit name comparator that walks
// the directory RAM and then the file RAM, one entry per cycle; a request
// walks at most DIR_SLOTS + FILE_SLOTS entries. The result sits in an
// output register, so it may wait for m_tready while s_tready returns high;
// a further request then waits at its end until that result is taken. No
// clearing pass is needed after reset.
module two_level_directory_table_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // s_tdata: func[1:0], dir_name[65:2], file_name[129:66], zero pad to 136
    input  wire logic [tldt_pkg::IN_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // m_tdata: status[2:0], dir_slot[6:3], file_slot[10:7], zero pad to 16
    output logic [tldt_pkg::OUT_W-1:0]     m_tdata
);

    import tldt_pkg::*;

    // Sequencer and request registers
    state_t                state_reg, state_next;
    func_t                 func_reg, func_next;
    logic [NAME_W-1:0]     dname_reg, dname_next;
    logic [NAME_W-1:0]     fname_reg, fname_next;
    logic [DIW-1:0]        dir_idx_reg, dir_idx_next;
    logic [FIW-1:0]        file_idx_reg, file_idx_next;
    logic [DCW-1:0]        dir_count_reg, dir_count_next;
    logic [FCW-1:0]        files_cnt_reg [DIR_SLOTS];

    // Pending result and output register
    status_t               res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_dslot_reg, res_dslot_next;
    logic [SLOT_W-1:0]     res_fslot_reg, res_fslot_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]      m_data_reg, m_data_next;

    // Count array write port
    logic                  fc_we;
    logic [DIW-1:0]        fc_sel;
    logic [FCW-1:0]        fc_wdata;

    // RAM ports
    logic                  dir_we;
    logic [DIW-1:0]        dir_waddr;
    logic [DIW-1:0]        dir_raddr;
    logic [NAME_W-1:0]     dir_rdata;
    logic                  file_we;
    logic [FAW-1:0]        file_waddr;
    logic [NAME_W-1:0]     file_wdata;
    logic [FAW-1:0]        file_raddr;
    logic [NAME_W-1:0]     file_rdata;

    // Shared name comparator and scan bounds
    logic [NAME_W-1:0]     cmp_a;
    logic [NAME_W-1:0]     cmp_b;
    logic                  name_hit;
    logic [FCW-1:0]        cur_cnt;
    logic                  dir_last;
    logic                  file_last;
    logic                  accept;
    func_t                 in_func;
    logic                  out_free;

    tldt_ram #(
        .DEPTH (DIR_SLOTS),
        .WIDTH (NAME_W)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dname_next),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    tldt_ram #(
        .DEPTH (FILE_DEPTH),
        .WIDTH (NAME_W)
    ) u_file_ram (
        .clk   (clk),
        .we    (file_we),
        .waddr (file_waddr),
        .wdata (file_wdata),
        .raddr (file_raddr),
        .rdata (file_rdata)
    );

    assign accept    = s_tvalid && s_tready;
    assign in_func   = func_t'(s_tdata[1:0]);
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // One comparator serves both walks: the RAM read data is registered and arrives
    // in the cycle after its address, so dir_idx_reg / file_idx_reg name the entry under test.
    assign cmp_a     = (state_reg == S_DSCAN) ? dir_rdata : file_rdata;
    assign cmp_b     = (state_reg == S_DSCAN) ? dname_reg : fname_reg;
    assign name_hit  = (cmp_a == cmp_b);
    assign cur_cnt   = files_cnt_reg[dir_idx_reg];
    assign dir_last  = ((DCW'(dir_idx_reg) + DCW'(1)) == dir_count_reg);
    assign file_last = ((FCW'(file_idx_reg) + FCW'(1)) == cur_cnt);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_func == FN_MKDIR || dir_count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DSCAN;
                    end
                end
            end
            S_DSCAN:
            begin
                if (name_hit)
                begin
                    if (func_reg == FN_MKFILE || cur_cnt == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FSCAN;
                    end
                end
                else if (dir_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_FSCAN:
            begin
                if (name_hit)
                begin
                    state_next = (func_reg == FN_DELETE) ? S_DEL : S_DONE;
                end
                else if (file_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DEL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM controls and result
    always_comb
    begin
        func_next       = func_reg;
        dname_next      = dname_reg;
        fname_next      = fname_reg;
        dir_idx_next    = dir_idx_reg;
        file_idx_next   = file_idx_reg;
        dir_count_next  = dir_count_reg;
        res_status_next = res_status_reg;
        res_dslot_next  = res_dslot_reg;
        res_fslot_next  = res_fslot_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        fc_we           = 1'b0;
        fc_sel          = dir_idx_reg;
        fc_wdata        = '0;
        dir_we          = 1'b0;
        dir_waddr       = dir_count_reg[DIW-1:0];
        file_we         = 1'b0;
        file_waddr      = file_addr(dir_idx_reg, file_idx_reg);
        file_wdata      = fname_reg;
        file_raddr      = '0;

        // Drop the result once the sink takes it
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next     = in_func;
                    dname_next    = s_tdata[2 +: NAME_W];
                    fname_next    = s_tdata[2 + NAME_W +: NAME_W];
                    dir_idx_next  = '0;
                    file_idx_next = '0;
                    res_dslot_next = '0;
                    res_fslot_next = '0;
                    if (in_func == FN_MKDIR)
                    begin
                        if (dir_count_reg >= DCW'(DIR_SLOTS))
                        begin
                            res_status_next = ST_DIR_FULL;
                        end
                        else
                        begin
                            // Append; the new directory starts empty
                            dir_we          = 1'b1;
                            fc_we           = 1'b1;
                            fc_sel          = dir_count_reg[DIW-1:0];
                            fc_wdata        = '0;
                            dir_count_next  = DCW'(dir_count_reg + DCW'(1));
                            res_status_next = ST_OK;
                            res_dslot_next  = SLOT_W'(dir_count_reg);
                        end
                    end
                    else if (dir_count_reg == '0)
                    begin
                        res_status_next = ST_NO_DIR;
                    end
                end
            end
            S_DSCAN:
            begin
                if (name_hit)
                begin
                    res_dslot_next = SLOT_W'(dir_idx_reg);
                    if (func_reg == FN_MKFILE)
                    begin
                        if (cur_cnt >= FCW'(FILE_SLOTS))
                        begin
                            res_status_next = ST_FILE_FULL;
                        end
                        else
                        begin
                            file_we         = 1'b1;
                            file_waddr      = file_addr(dir_idx_reg, FIW'(cur_cnt));
                            fc_we           = 1'b1;
                            fc_wdata        = FCW'(cur_cnt + FCW'(1));
                            res_status_next = ST_OK;
                            res_fslot_next  = SLOT_W'(cur_cnt);
                        end
                    end
                    else if (cur_cnt == '0)
                    begin
                        res_status_next = ST_NO_FILE;
                    end
                end
                else if (dir_last)
                begin
                    res_status_next = ST_NO_DIR;
                end
                else
                begin
                    dir_idx_next = DIW'(dir_idx_reg + DIW'(1));
                end
            end
            S_FSCAN:
            begin
                if (name_hit)
                begin
                    res_status_next = ST_OK;
                    res_fslot_next  = SLOT_W'(file_idx_reg);
                end
                else if (file_last)
                begin
                    res_status_next = ST_NO_FILE;
                end
                else
                begin
                    file_idx_next = FIW'(file_idx_reg + FIW'(1));
                end
            end
            S_DEL:
            begin
                // Move the last file into the freed slot
                file_we    = 1'b1;
                file_wdata = file_rdata;
                fc_we      = 1'b1;
                fc_wdata   = FCW'(cur_cnt - FCW'(1));
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'({res_fslot_reg, res_dslot_reg, res_status_reg});
                end
            end
            default:
            begin
            end
        endcase

        // Read addresses follow the next walk position; a delete fetches the
        // last file of the matched directory instead.
        dir_raddr  = dir_idx_next;
        file_raddr = file_addr(dir_idx_next, file_idx_next);
        if (state_reg == S_FSCAN && name_hit && func_reg == FN_DELETE)
        begin
            file_raddr = file_addr(dir_idx_reg, FIW'(cur_cnt - FCW'(1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dir_count_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < DIR_SLOTS; i++)
            begin
                files_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            dir_count_reg <= dir_count_next;
            m_valid_reg   <= m_valid_next;
            if (fc_we)
            begin
                files_cnt_reg[fc_sel] <= fc_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        dname_reg      <= dname_next;
        fname_reg      <= fname_next;
        dir_idx_reg    <= dir_idx_next;
        file_idx_reg   <= file_idx_next;
        res_status_reg <= res_status_next;
        res_dslot_reg  <= res_dslot_next;
        res_fslot_reg  <= res_fslot_next;
        m_data_reg     <= m_data_next;
    end

`ifndef SYNTHESIS
    // One request in flight: the input closes right after a beat is taken
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a request is in flight");

    // The directory count never passes the table size
    a_dir_count: assert property (@(posedge clk) disable iff (!rst_n)
        dir_count_reg <= DCW'(DIR_SLOTS))
        else $error("directory count overflow");

    // A file walk stays inside the matched directory's files
    a_file_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FSCAN) |-> (FCW'(file_idx_reg) < cur_cnt))
        else $error("file walk beyond directory fill");

    // A directory walk stays below the directory count
    a_dir_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSCAN) |-> (DCW'(dir_idx_reg) < dir_count_reg))
        else $error("directory walk beyond table fill");
`endif

endmodule

`default_nettype wire

[rtl/tldt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used by two_level_directory_table_core for the name stores.
`default_nettype none

module tldt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
